/* rtl/core/sorted_set_insert_lookup_core_macros.svh */
`ifndef SORTED_SET_INSERT_LOOKUP_CORE_MACROS_SVH
`define SORTED_SET_INSERT_LOOKUP_CORE_MACROS_SVH

// same-cycle implication
`define SSIL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssil check failed");

// next-cycle implication
`define SSIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssil check failed");

`endif

/* rtl/core/ssil_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssil_pkg;

   localparam int unsigned CAPACITY_DEF  = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned ENTRY_COUNT_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_res_type;

   typedef struct packed {
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     overflow;
      logic                     stored;
      logic                     present;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/ssil_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssil_cmp (
   input  wire logic signed [ssil_pkg::VALUE_W-1:0] a,
   input  wire logic signed [ssil_pkg::VALUE_W-1:0] b,
   output ssil_pkg::cmp_res_type                    res
);
   import ssil_pkg::*;

   assign res.less  = (a < b);
   assign res.equal = (a == b);

endmodule

`default_nettype wire

/* rtl/core/ssil_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssil_store #(
   parameter  int unsigned DEPTH = ssil_pkg::CAPACITY_DEF,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [ssil_pkg::VALUE_W-1:0]  wr_data,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic      [ssil_pkg::VALUE_W-1:0]  rd_data
);
   import ssil_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/ssil_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssil_seq #(
   parameter  int unsigned CAPACITY = ssil_pkg::CAPACITY_DEF,
   localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int unsigned CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         op,
   input  wire logic [ssil_pkg::VALUE_W-1:0] value,
   output logic                              idle,
   input  wire logic                         out_free,
   output logic                              done,
   output ssil_pkg::rsp_type                 result,
   output logic      [AW-1:0]                rd_addr,
   input  wire logic [ssil_pkg::VALUE_W-1:0] rd_data,
   output logic                              wr_en,
   output logic      [AW-1:0]                wr_addr,
   output logic      [ssil_pkg::VALUE_W-1:0] wr_data,
   output logic      [ssil_pkg::VALUE_W-1:0] cmp_a,
   output logic      [ssil_pkg::VALUE_W-1:0] cmp_b,
   input  wire ssil_pkg::cmp_res_type        cmp_res
);
   import ssil_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_MOVE   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [CW-1:0] FULL = CW'(CAPACITY);

   logic [2:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               present_ff, present_in;
   logic               stored_ff, stored_in;
   logic               overflow_ff, overflow_in;
   logic [CW-1:0]      idx_dec;
   logic [31:0]        count_ext;

   assign idx_dec = idx_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      present_in  = present_ff;
      stored_in   = stored_ff;
      overflow_in = overflow_ff;
      rd_addr     = idx_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = rd_data;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op;
               value_in = value;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               pos_in     = count_ff;
               present_in = 1'b0;
               state_in   = S_DECIDE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cmp_res.less) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               pos_in     = idx_ff;
               present_in = cmp_res.equal;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            stored_in   = 1'b0;
            overflow_in = 1'b0;
            state_in    = S_DONE;
            if (op_ff == OP_INSERT && !present_ff) begin
               if (count_ff == FULL) begin
                  overflow_in = 1'b1;
               end else begin
                  idx_in   = count_ff;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            rd_addr = idx_dec[AW-1:0];
            if (idx_ff == pos_ff) begin
               wr_en     = 1'b1;
               wr_data   = value_ff;
               count_in  = count_ff + 1'b1;
               stored_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = S_SHIFT;
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      present_ff  <= present_in;
      stored_ff   <= stored_in;
      overflow_ff <= overflow_in;
   end

   assign count_ext          = 32'(count_ff);
   assign idle               = (state_ff == S_IDLE);
   assign result.entry_count = count_ext[ENTRY_COUNT_W-1:0];
   assign result.overflow    = overflow_ff;
   assign result.stored      = stored_ff;
   assign result.present     = present_ff;
   assign cmp_a              = rd_data;
   assign cmp_b              = value_ff;

endmodule

`default_nettype wire

/* rtl/core/sorted_set_insert_lookup_core.sv */
// a query or duplicate scans entries up to pos; a stored insert then shifts pos..count-1
// up one place (pos = first entry not below the value, count = entries held)
// throughput: requests are taken only while idle, after the last response is registered;
// set by the single compare unit and the one-read one-write table port
// reset: synchronous, empties the set and drops a pending response; table data is kept
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_lookup_core #(
   parameter int unsigned CAPACITY = ssil_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value
   input  wire logic [0:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // entry_count[4:0], overflow, stored, present
);
   import ssil_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic               idle;
   logic               start;
   logic               out_free;
   logic               done;
   rsp_type            result;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] cmp_a;
   logic [VALUE_W-1:0] cmp_b;
   cmp_res_type        cmp_res;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign start    = req_tvalid && idle;
   assign out_free = !rsp_valid_ff || rsp_tready;

   ssil_seq #(.CAPACITY(CAPACITY)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_tuser[0]),
      .value    (req_tdata),
      .idle     (idle),
      .out_free (out_free),
      .done     (done),
      .result   (result),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .cmp_a    (cmp_a),
      .cmp_b    (cmp_b),
      .cmp_res  (cmp_res)
   );

   ssil_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssil_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/ssil_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_insert_lookup_core_macros.svh"

module ssil_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   logic req_beat;
   logic rsp_wait;
   logic rsp_bad_flags;

   assign req_beat      = req_tvalid && req_tready;
   assign rsp_wait      = rsp_tvalid && !rsp_tready;
   assign rsp_bad_flags = rsp_tdata[1] && (rsp_tdata[0] || rsp_tdata[2]);

   // reset empties the response register
   `SSIL_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)
   // a held response keeps its data
   `SSIL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))
   // the core is busy right after taking a beat
   `SSIL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready)
   // no response comes out on the cycle after an item starts from empty output
   `SSIL_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_beat && !rsp_tvalid, !rsp_tvalid)
   // a stored entry was neither present nor an overflow
   `SSIL_ASSERT_NOW(a_flags_excl, clock, reset, rsp_tvalid, !rsp_bad_flags)

endmodule

bind sorted_set_insert_lookup_core ssil_checker u_ssil_checker (.*);

`default_nettype wire
